FILE: rtl/sha_pkg.sv
// ============================================================================
// sha_pkg: shared types and constants of the SHA-256 stream hasher
// Holds the hash word types, the initial hash value, the round constant
// table and the controller's command and status records.
// ============================================================================
package sha_pkg;

	typedef logic [31:0] word_t;

	// Eight hash words; word k sits at index [k].
	typedef logic [7:0][31:0] hash_t;

	// Initial hash value, listed from word 7 down to word 0.
	localparam hash_t IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [5:0] LAST_ROUND    = 6'd63;

	// Source of the byte that the datapath shifts into the block.
	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      push;
		byte_src_t src;
		logic      latch_len;
		logic      round;
		logic [5:0] rnd;
		logic      fold;
		logic      finish;
	} dp_cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic [5:0] pos;
		logic       out_busy;
	} dp_stat_t;

	// SHA-256 round constants.
	function automatic word_t k_const(input logic [5:0] idx);
		word_t k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/sha_in_if.sv
// ============================================================================
// sha_in_if: message byte channel
// Carries one message byte per beat with its byte and end flags.
// ============================================================================
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       carries_byte;
	logic       message_end;

	modport source (output valid, output data_byte, output carries_byte,
		output message_end, input ready);
	modport sink (input valid, input data_byte, input carries_byte,
		input message_end, output ready);
endinterface

FILE: rtl/sha_out_if.sv
// ============================================================================
// sha_out_if: digest word channel
// Carries one 32-bit digest word per beat with its position in the digest.
// ============================================================================
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;

	modport source (output valid, output digest_word, output word_number,
		output final_word, input ready);
	modport sink (input valid, input digest_word, input word_number,
		input final_word, output ready);
endinterface

FILE: rtl/sha256_stream_hasher_core.sv
// ============================================================================
// sha256_stream_hasher_core: SHA-256 hasher fed one message byte per beat
// Top level joining the controller, the datapath and the output buffer.
// ============================================================================
// A beat on msg carries one message byte, or none when carries_byte is low;
// message_end closes the message, and an end beat without a byte closes it
// without adding one. Bytes are taken one per cycle while msg.ready is high.
// The 64th byte of each block starts the compression, which holds msg.ready
// low through 64 rounds of the single round unit, one per cycle, and the
// fold. Closing a message pushes the pad mark, up to 63 zero bytes and eight
// length bytes, with one or two compressions, then hands the digest to the
// output buffer once that buffer is free. The digest leaves on the digest
// channel as eight word beats, word 0 first, while the next message is
// already loading; a second digest waits only if the first one has not
// drained yet. No clearing pass follows reset.
module sha256_stream_hasher_core
	import sha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	sha_in_if.sink   msg,
	sha_out_if.source digest
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [5:0] pos;
	logic       out_busy;
	hash_t      chain;

	assign stat.pos      = pos;
	assign stat.out_busy = out_busy;

	// Sequencer.
	sha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (msg.valid),
		.in_carries (msg.carries_byte),
		.in_end     (msg.message_end),
		.in_ready   (msg.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Hash datapath.
	sha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (msg.data_byte),
		.pos       (pos),
		.chain     (chain)
	);

	// Digest output buffer.
	sha_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (cmd.finish),
		.digest_in   (chain),
		.busy        (out_busy),
		.valid       (digest.valid),
		.ready       (digest.ready),
		.digest_word (digest.digest_word),
		.word_number (digest.word_number),
		.final_word  (digest.final_word)
	);

endmodule

FILE: rtl/sha_ctrl.sv
// ============================================================================
// sha_ctrl: hasher controller
// Sequences byte loading, message padding, the 64 compression rounds, the
// chaining fold and the hand-off of each digest to the output buffer.
// ============================================================================
module sha_ctrl
	import sha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_carries,
	input  logic     in_end,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [5:0] rnd_q, rnd_d;
	logic       at_last;

	assign at_last = (stat.pos == LAST_POS);

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			rnd_q   <= rnd_d;
		end
	end

	// Next state. Filling the last byte of a block always starts a compression,
	// and the state to resume afterwards is kept in ret_q.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		rnd_d   = rnd_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_carries && at_last) begin
						state_d = ST_ROUND;
						rnd_d   = '0;
						ret_d   = in_end ? ST_PAD_MARK : ST_IDLE;
					end else if (in_end) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				if (at_last) begin
					state_d = ST_ROUND;
					rnd_d   = '0;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (stat.pos == LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else if (at_last) begin
					state_d = ST_ROUND;
					rnd_d   = '0;
					ret_d   = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (at_last) begin
					state_d = ST_ROUND;
					rnd_d   = '0;
					ret_d   = ST_DONE;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end else begin
					rnd_d = rnd_q + 6'd1;
				end
			end
			ST_FOLD: begin
				state_d = ret_q;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath commands and input handshake.
	always_comb begin
		cmd       = '0;
		cmd.src   = SRC_INPUT;
		cmd.rnd   = rnd_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.push = in_valid && in_carries;
			end
			ST_PAD_MARK: begin
				cmd.push      = 1'b1;
				cmd.src       = SRC_MARK;
				cmd.latch_len = 1'b1;
			end
			ST_PAD_ZERO: begin
				cmd.push = (stat.pos != LEN_POS);
				cmd.src  = SRC_ZERO;
			end
			ST_PAD_LEN: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A block's last byte is followed by round zero of its compression.
	a_last_byte_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && at_last) |=> (state_q == ST_ROUND && rnd_q == 6'd0))
		else $error("last byte of a block did not start the rounds");

	// The fold comes only after the final round.
	a_fold_after_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> ($past(state_q) == ST_ROUND && $past(rnd_q) == LAST_ROUND))
		else $error("fold without a full set of rounds");

	// The length bytes fill exactly the last eight positions of a block.
	a_len_position: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD_LEN) |-> (stat.pos[5:3] == 3'b111))
		else $error("length byte outside the last eight positions");

	// A digest is handed over only to an empty output buffer.
	a_finish_free_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !stat.out_busy)
		else $error("digest handed to a busy output buffer");
`endif

endmodule

FILE: rtl/sha_dp.sv
// ============================================================================
// sha_dp: hasher datapath
// Byte packing, the 16-word message schedule window, the working variables
// with one SHA-256 round per cycle, the chaining value and the byte counter.
// ============================================================================
module sha_dp
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  logic [7:0] data_byte,
	output logic [5:0] pos,
	output hash_t      chain
);

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	hash_t        chain_q;
	hash_t        work_q;
	word_t        win_q [16];
	word_t        part_q;
	logic [60:0]  count_q;
	logic [63:0]  len_q;
	logic [7:0]   push_byte;
	logic [63:0]  len_shift;
	word_t        word_next;
	word_t        sched_next;
	word_t        t1;
	word_t        t2;

	assign pos   = count_q[5:0];
	assign chain = chain_q;

	// Byte to shift in: message byte, pad mark, zero or a length byte.
	assign len_shift = len_q >> {~count_q[2:0], 3'b000};
	always_comb begin
		case (cmd.src)
			SRC_INPUT: push_byte = data_byte;
			SRC_MARK:  push_byte = PAD_MARK_BYTE;
			SRC_ZERO:  push_byte = 8'h00;
			SRC_LEN:   push_byte = len_shift[7:0];
			default:   push_byte = 8'h00;
		endcase
	end

	assign word_next = {part_q[23:0], push_byte};

	// Schedule word for sixteen rounds ahead and the round function.
	assign sched_next = win_q[0] + sml_sig0(win_q[1]) + win_q[9] + sml_sig1(win_q[14]);
	assign t1 = work_q[7] + big_sig1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ k_const(cmd.rnd) + win_q[0];
	assign t2 = big_sig0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	// Byte counter, partial word and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			part_q  <= '0;
			chain_q <= IV;
		end else if (cmd.finish) begin
			count_q <= '0;
			part_q  <= '0;
			chain_q <= IV;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 61'd1;
				part_q  <= (count_q[1:0] == 2'b11) ? '0 : word_next;
			end
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
		end
	end

	// Bit length of the message, taken as the pad mark goes in.
	always_ff @(posedge clk) begin
		if (cmd.latch_len) begin
			len_q <= {count_q, 3'b000};
		end
	end

	// Schedule window: complete words shift in while loading, and each round
	// shifts out the word it used and appends the next schedule word.
	always_ff @(posedge clk) begin
		if ((cmd.push && count_q[1:0] == 2'b11) || cmd.round) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[15] <= cmd.round ? sched_next : word_next;
		end
	end

	// Working variables: loaded from the chain with a block's last byte.
	always_ff @(posedge clk) begin
		if (cmd.push && count_q[5:0] == LAST_POS) begin
			work_q <= chain_q;
		end else if (cmd.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

FILE: rtl/sha_obuf.sv
// ============================================================================
// sha_obuf: digest output buffer
// Holds one finished digest and sends it as eight word beats, word 0 first,
// so that the next message can be taken in while the words drain.
// ============================================================================
module sha_obuf
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  hash_t       digest_in,
	output logic        busy,
	output logic        valid,
	input  logic        ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	hash_t      dig_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       beat;

	assign beat        = busy_q && ready;
	assign busy        = busy_q;
	assign valid       = busy_q;
	assign digest_word = dig_q[0];
	assign word_number = idx_q;
	assign final_word  = (idx_q == 3'd7);

	// Beat counter and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Digest words shift toward the output on each beat.
	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= digest_in;
		end else if (beat) begin
			for (int i = 0; i < 7; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

endmodule
